// File: rtl/core/language_tag_validator_assert.svh
// Assertion macros for the language tag validator.
// Used by modules that check their own control logic; needs clk and arst_n in scope.
`ifndef LANGUAGE_TAG_VALIDATOR_ASSERT_SVH
`define LANGUAGE_TAG_VALIDATOR_ASSERT_SVH

// Same-cycle implication.
`define LTV_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ltv assertion failed");

// Next-cycle implication.
`define LTV_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ltv assertion failed");

`endif

// File: rtl/core/ltv_pkg.sv
// Package for the language tag validator: sizes, grammar state codes, payload types.
// No dependencies.
`timescale 1ns / 1ps
package ltv_pkg;
	localparam int MAX_VARIANTS = 8;
	localparam int CNT_W = $clog2(MAX_VARIANTS + 1);
	localparam int NSING = 36;

	localparam logic [7:0] CH_HYPHEN = 8'h2d;
	localparam logic [7:0] CH_U = 8'h75;
	localparam logic [7:0] CH_T = 8'h74;
	localparam logic [7:0] CH_X = 8'h78;

	typedef enum logic [4:0] {
		S_LANG, S_M_LANG, S_M_SCRIPT, S_M_VAR, S_U_FIRST, S_U_ATTR, S_U_KW,
		S_T_FIRST, S_TL_LANG, S_TL_SCRIPT, S_TL_VAR, S_T_NEEDVAL, S_T_VAL,
		S_X_FIRST, S_X_VAL, S_O_FIRST, S_O_VAL, S_OVF
	} gstate_t;

	typedef struct packed {
		logic [7:0] ch;
		logic       last;
	} in_item_t;

	typedef struct packed {
		logic valid_res;
		logic overflow;
	} out_item_t;
endpackage

// File: rtl/core/ltv_cell.sv
// One variant cell: holds a stored subtag, passes it to the next cell on push.
// Depends on nothing but the clock.
`timescale 1ns / 1ps
module ltv_cell (
	input  logic        clk,
	input  logic        push,
	input  logic        active,
	input  logic [63:0] din,
	input  logic [63:0] key,
	output logic [63:0] dout,
	output logic        hit
);
	logic [63:0] data_q;

	always_ff @(posedge clk) begin
		if (push) begin
			data_q <= din;
		end
	end

	assign dout = data_q;
	assign hit = active && (data_q == key);
endmodule

// File: rtl/core/ltv_var_chain.sv
// Row of variant cells with fill count; reports a repeat and a full store.
// Depends on ltv_pkg and ltv_cell.
`timescale 1ns / 1ps
module ltv_var_chain (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  logic        clr,
	input  logic [63:0] key,
	output logic        hit,
	output logic        full
);
	import ltv_pkg::*;

	logic [CNT_W-1:0] count_q;
	logic [63:0] link [MAX_VARIANTS+1];
	logic [MAX_VARIANTS-1:0] hits;

	assign link[0] = key;

	for (genvar i = 0; i < MAX_VARIANTS; i++) begin : g_cell
		ltv_cell u_cell (
			.clk    (clk),
			.push   (push),
			.active (CNT_W'(i) < count_q),
			.din    (link[i]),
			.key    (key),
			.dout   (link[i+1]),
			.hit    (hits[i])
		);
	end

	assign hit = |hits;
	assign full = count_q >= CNT_W'(MAX_VARIANTS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (clr) begin
			count_q <= '0;
		end else if (push) begin
			count_q <= count_q + 1'b1;
		end
	end
endmodule

// File: rtl/core/language_tag_validator.sv
// Top level of the language tag validator: subtag collection, grammar state, result register.
// Depends on ltv_pkg, ltv_var_chain and language_tag_validator_assert.svh.
//
//  channel | dir | payload    | handshake
//  in      | in  | in_item_t  | in_valid / in_stall
//  out     | out | out_item_t | out_valid / out_stall
//
// One byte per cycle when not stalled; a subtag is judged in the cycle its hyphen or final byte arrives.
// The variant compare runs across all cells of the chain in that same cycle.
// A result is registered and shows in the cycle after the final byte is taken. arst_n clears all control state.
// Only a final byte stalls, and only while an earlier result waits under out_stall.
`timescale 1ns / 1ps
module language_tag_validator (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  ltv_pkg::in_item_t in_item,
	output logic              out_valid,
	input  logic              out_stall,
	output ltv_pkg::out_item_t out_item
);
	import ltv_pkg::*;

	gstate_t st_q, st_n;
	logic [3:0] len_q, len_c;
	logic [2:0] fl_q, fl_c;
	logic [63:0] chars_q, chars_c;
	logic [NSING-1:0] sing_q;
	logic fail_q, fail_n, push_c, tclr_c, sing_set, do_ext, ext_ok;
	logic out_valid_q;
	out_item_t out_q;
	logic acc, acc_last, is_hy, do_feed, vhit, vfull;
	logic [7:0] c, lc, c0, c1;
	logic [2:0] f;
	logic in_t, stage0, stage01;
	logic al, dg, an, is_lang, is_script, is_region, is_variant, is_ukey, is_tkey;
	logic val38, an18, an28;
	logic [5:0] sidx;
	gstate_t ext_st;

	assign acc = in_valid && !in_stall;
	assign acc_last = acc && in_item.last;
	assign in_stall = out_valid_q && out_stall && in_item.last;
	assign c = in_item.ch;
	assign is_hy = c == CH_HYPHEN;
	assign do_feed = is_hy || in_item.last;

	always_comb begin
		f = '0;
		if ((c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a)) begin
			f = 3'b101;
		end
		if (c >= 8'h30 && c <= 8'h39) begin
			f = 3'b110;
		end
		lc = (c >= 8'h41 && c <= 8'h5a) ? c + 8'd32 : c;
		len_c = len_q;
		fl_c = fl_q;
		chars_c = chars_q;
		if (!is_hy) begin
			fl_c = fl_q & f;
			if (len_q < 4'd8) begin
				chars_c = chars_q | (64'(lc) << {len_q[2:0], 3'b000});
			end
			if (len_q != 4'd15) begin
				len_c = len_q + 4'd1;
			end
		end
	end

	assign c0 = chars_c[7:0];
	assign c1 = chars_c[15:8];
	assign al = fl_c[0];
	assign dg = fl_c[1];
	assign an = fl_c[2];
	assign is_lang = al && ((len_c >= 4'd2 && len_c <= 4'd3) || (len_c >= 4'd5 && len_c <= 4'd8));
	assign is_script = len_c == 4'd4 && al;
	assign is_region = (len_c == 4'd2 && al) || (len_c == 4'd3 && dg);
	assign val38 = len_c >= 4'd3 && len_c <= 4'd8 && an;
	assign an18 = len_c >= 4'd1 && len_c <= 4'd8 && an;
	assign an28 = len_c >= 4'd2 && len_c <= 4'd8 && an;
	assign is_variant = (len_c >= 4'd5 && len_c <= 4'd8 && an)
		|| (len_c == 4'd4 && an && c0 >= 8'h30 && c0 <= 8'h39);
	assign is_ukey = len_c == 4'd2 && an && c1 >= 8'h61 && c1 <= 8'h7a;
	assign is_tkey = len_c == 4'd2 && c0 >= 8'h61 && c0 <= 8'h7a
		&& c1 >= 8'h30 && c1 <= 8'h39;

	assign sidx = (c0 <= 8'h39) ? 6'(c0 - 8'h30) : 6'(c0 - 8'h57);
	assign ext_ok = len_c == 4'd1 && an && !sing_q[sidx];

	always_comb begin
		priority if (c0 == CH_U) begin
			ext_st = S_U_FIRST;
		end else if (c0 == CH_T) begin
			ext_st = S_T_FIRST;
		end else if (c0 == CH_X) begin
			ext_st = S_X_FIRST;
		end else begin
			ext_st = S_O_FIRST;
		end
	end

	assign in_t = st_q == S_TL_LANG || st_q == S_TL_SCRIPT || st_q == S_TL_VAR;
	assign stage0 = st_q == S_M_LANG || st_q == S_TL_LANG;
	assign stage01 = stage0 || st_q == S_M_SCRIPT || st_q == S_TL_SCRIPT;

	always_comb begin
		st_n = st_q;
		fail_n = 1'b0;
		push_c = 1'b0;
		tclr_c = 1'b0;
		do_ext = 1'b0;
		sing_set = 1'b0;
		if (do_feed && !fail_q) begin
			unique case (st_q)
				S_LANG: begin
					if (is_lang) st_n = S_M_LANG; else fail_n = 1'b1;
				end
				S_M_LANG, S_M_SCRIPT, S_M_VAR, S_TL_LANG, S_TL_SCRIPT, S_TL_VAR: begin
					priority if (stage0 && is_script) begin
						st_n = in_t ? S_TL_SCRIPT : S_M_SCRIPT;
					end else if (stage01 && is_region) begin
						st_n = in_t ? S_TL_VAR : S_M_VAR;
					end else if (is_variant) begin
						priority if (vhit) begin
							fail_n = 1'b1;
						end else if (vfull) begin
							st_n = S_OVF;
							fail_n = 1'b1;
						end else begin
							push_c = 1'b1;
							st_n = in_t ? S_TL_VAR : S_M_VAR;
						end
					end else if (in_t && is_tkey) begin
						st_n = S_T_NEEDVAL;
					end else begin
						do_ext = 1'b1;
					end
				end
				S_U_FIRST: begin
					priority if (val38) st_n = S_U_ATTR;
					else if (is_ukey) st_n = S_U_KW;
					else fail_n = 1'b1;
				end
				S_U_ATTR: begin
					priority if (val38) st_n = S_U_ATTR;
					else if (is_ukey) st_n = S_U_KW;
					else do_ext = 1'b1;
				end
				S_U_KW: begin
					if (val38 || is_ukey) st_n = S_U_KW; else do_ext = 1'b1;
				end
				S_T_FIRST: begin
					priority if (is_lang) begin
						tclr_c = 1'b1;
						st_n = S_TL_LANG;
					end else if (is_tkey) begin
						st_n = S_T_NEEDVAL;
					end else begin
						fail_n = 1'b1;
					end
				end
				S_T_NEEDVAL: begin
					if (val38) st_n = S_T_VAL; else fail_n = 1'b1;
				end
				S_T_VAL: begin
					priority if (val38) st_n = S_T_VAL;
					else if (is_tkey) st_n = S_T_NEEDVAL;
					else do_ext = 1'b1;
				end
				S_X_FIRST, S_X_VAL: begin
					if (an18) st_n = S_X_VAL; else fail_n = 1'b1;
				end
				S_O_FIRST: begin
					if (an28) st_n = S_O_VAL; else fail_n = 1'b1;
				end
				S_O_VAL: begin
					if (an28) st_n = S_O_VAL; else do_ext = 1'b1;
				end
				default: fail_n = 1'b1;
			endcase
			if (do_ext) begin
				if (ext_ok) begin
					st_n = ext_st;
					sing_set = 1'b1;
				end else begin
					fail_n = 1'b1;
				end
			end
		end
	end

	ltv_var_chain u_chain (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (acc && push_c),
		.clr    (acc_last || (acc && tclr_c)),
		.key    (chars_c),
		.hit    (vhit),
		.full   (vfull)
	);

	logic accepting;
	always_comb begin
		unique case (st_n)
			S_M_LANG, S_M_SCRIPT, S_M_VAR, S_U_ATTR, S_U_KW, S_TL_LANG, S_TL_SCRIPT,
			S_TL_VAR, S_T_VAL, S_X_VAL, S_O_VAL: accepting = 1'b1;
			default: accepting = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_LANG;
			fail_q <= 1'b0;
			sing_q <= '0;
			len_q <= '0;
			fl_q <= '1;
			chars_q <= '0;
		end else if (acc_last || (acc && is_hy)) begin
			if (acc_last) begin
				st_q <= S_LANG;
				fail_q <= 1'b0;
				sing_q <= '0;
			end else begin
				st_q <= st_n;
				fail_q <= fail_q || fail_n;
				if (sing_set) sing_q[sidx] <= 1'b1;
			end
			len_q <= '0;
			fl_q <= '1;
			chars_q <= '0;
		end else if (acc) begin
			len_q <= len_c;
			fl_q <= fl_c;
			chars_q <= chars_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (acc_last) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc_last) begin
			out_q.valid_res <= !fail_q && !fail_n && accepting && !is_hy;
			out_q.overflow <= st_n == S_OVF;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item = out_q;

`include "language_tag_validator_assert.svh"
	`LTV_ASSERT_NXT(a_last_gives_result, acc_last, out_valid_q)
	`LTV_ASSERT_IMP(a_ovf_invalid, out_valid_q, !(out_q.overflow && out_q.valid_res))
	`LTV_ASSERT_IMP(a_stall_only_full, in_stall, out_valid_q && in_item.last)
	`LTV_ASSERT_NXT(a_fresh_tag, acc_last, st_q == S_LANG && !fail_q && sing_q == '0)
endmodule
